// File: rtl/sxf_pkg.sv
package sxf_pkg;

    // Item kinds
    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_DRAW  = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    // Pixels in one sprite row
    localparam int SPRITE_BITS = 8;

    // Frame memory control from the sequencer
    typedef struct packed {
        logic rd_en;    // read one row, data next cycle
        logic wr_en;    // write one row back
        logic clr_all;  // blank the whole frame
    } t_mem_ctl;

endpackage

// File: rtl/sprite_xor_framebuffer_core.sv
// XOR sprite framebuffer, monochrome, SCREEN_WIDTH x SCREEN_HEIGHT pixels.
// Input channel (i_in_valid / o_in_ready) carries one word per item: clear
// screen, draw one 8-pixel sprite row at (x, y + sprite line), or read one
// pixel. Coordinates wrap modulo the screen size. Output channel
// (o_out_valid / i_out_ready) returns exactly one word per item: the
// collision flag after the item and, for a read, the pixel value.
// A draw is a read-modify-write of one frame row: the row is read from the
// frame memory at acceptance and is available in the next cycle; the XOR,
// collision check and write-back happen once the output register is free.
// A read only reads its row. No new item is taken until the current one
// finishes. A clear drops the per-row valid bits.
// Results go into an output register, so the next item may be accepted
// while a result waits. If the receiver stalls with a result still held,
// the next item waits in S_EXEC and no new item is taken.
// Reset blanks the frame (all rows read as zero) and clears the collision
// flag; the block is ready once reset is released.
module sprite_xor_framebuffer_core #(
    parameter int SCREEN_WIDTH  = 64,
    parameter int SCREEN_HEIGHT = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_kind,
    input  logic [7:0] i_x_pos,
    input  logic [7:0] i_y_pos,
    input  logic [3:0] i_sprite_line,
    input  logic [7:0] i_sprite_byte,
    input  logic       i_first_row,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_collision,
    output logic       o_pixel_on
);

    localparam int RW = $clog2(SCREEN_HEIGHT);
    localparam int CW = $clog2(SCREEN_WIDTH);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state                r_state;
    logic [1:0]            r_kind;
    logic                  r_first;
    logic [RW-1:0]         r_row;
    logic [CW-1:0]         r_col;
    logic [SCREEN_WIDTH-1:0] r_mask;
    logic                  r_coll;
    logic                  r_out_valid;
    logic                  r_out_coll;
    logic                  r_out_pix;

    logic [RW-1:0]           draw_row;
    logic [RW-1:0]           read_row;
    logic [CW-1:0]           read_col;
    logic [SCREEN_WIDTH-1:0] draw_mask;
    logic [SCREEN_WIDTH-1:0] rd_data;
    logic [RW-1:0]           rd_addr;
    sxf_pkg::t_mem_ctl       mem_ctl;
    logic                    in_acc;
    logic                    done;
    logic                    n_coll;
    logic                    n_pix;

    sxf_wrap #(
        .SCREEN_WIDTH (SCREEN_WIDTH),
        .SCREEN_HEIGHT(SCREEN_HEIGHT)
    ) u_wrap (
        .i_x_pos      (i_x_pos),
        .i_y_pos      (i_y_pos),
        .i_sprite_line(i_sprite_line),
        .i_sprite_byte(i_sprite_byte),
        .o_draw_row   (draw_row),
        .o_read_row   (read_row),
        .o_read_col   (read_col),
        .o_draw_mask  (draw_mask)
    );

    sxf_frame_mem #(
        .ROWS(SCREEN_HEIGHT),
        .COLS(SCREEN_WIDTH)
    ) u_mem (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (mem_ctl),
        .i_rd_addr(rd_addr),
        .i_wr_addr(r_row),
        .i_wr_data(rd_data ^ r_mask),
        .o_rd_data(rd_data)
    );

    // Handshake and memory control
    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign done       = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);
    assign rd_addr    = (i_kind == sxf_pkg::KIND_READ) ? read_row : draw_row;

    always_comb begin
        mem_ctl.rd_en   = in_acc;
        mem_ctl.clr_all = in_acc && (i_kind == sxf_pkg::KIND_CLEAR);
        mem_ctl.wr_en   = done && (r_kind == sxf_pkg::KIND_DRAW);
    end

    // Result of the item in S_EXEC
    always_comb begin
        n_coll = r_coll;
        n_pix  = 1'b0;
        unique case (r_kind)
            sxf_pkg::KIND_DRAW: begin
                n_coll = (r_coll && !r_first) || ((rd_data & r_mask) != '0);
            end
            sxf_pkg::KIND_READ: begin
                n_pix = rd_data[r_col];
            end
            default: begin
                n_pix = 1'b0;
            end
        endcase
    end

    // Sequencer, item registers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_coll      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_kind  <= i_kind;
                        r_first <= i_first_row;
                        r_row   <= draw_row;
                        r_col   <= read_col;
                        r_mask  <= draw_mask;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (done) begin
                        r_coll     <= n_coll;
                        r_out_coll <= n_coll;
                        r_out_pix  <= n_pix;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            // Output word: loaded when an item finishes, dropped when taken
            if (done) begin
                r_out_valid <= 1'b1;
            end else if (o_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_collision = r_out_coll;
    assign o_pixel_on  = r_out_pix;

endmodule

// File: rtl/sxf_wrap.sv
// Coordinate wrap: row addresses and the 8-pixel column mask of a draw,
// column of a read. All wrapping is modulo the screen size.
module sxf_wrap #(
    parameter int SCREEN_WIDTH  = 64,
    parameter int SCREEN_HEIGHT = 32
) (
    input  logic [7:0]                       i_x_pos,
    input  logic [7:0]                       i_y_pos,
    input  logic [3:0]                       i_sprite_line,
    input  logic [7:0]                       i_sprite_byte,
    output logic [$clog2(SCREEN_HEIGHT)-1:0] o_draw_row,
    output logic [$clog2(SCREEN_HEIGHT)-1:0] o_read_row,
    output logic [$clog2(SCREEN_WIDTH)-1:0]  o_read_col,
    output logic [SCREEN_WIDTH-1:0]          o_draw_mask
);

    localparam int RW = $clog2(SCREEN_HEIGHT);
    localparam int CW = $clog2(SCREEN_WIDTH);
    localparam int SPRITE_BITS_L = sxf_pkg::SPRITE_BITS;

    localparam logic [RW+1:0] HEIGHT_V = (RW+2)'(SCREEN_HEIGHT);
    localparam logic [CW:0]   WIDTH_V  = (CW+1)'(SCREEN_WIDTH);

    typedef logic [RW-1:0] t_row_tab [256];
    typedef logic [CW-1:0] t_col_tab [256];

    // Constant tables of byte value modulo the screen size
    function automatic t_row_tab f_row_tab();
        t_row_tab tab;
        for (int v = 0; v < 256; v++) begin
            tab[v] = RW'(v % SCREEN_HEIGHT);
        end
        return tab;
    endfunction

    function automatic t_col_tab f_col_tab();
        t_col_tab tab;
        for (int v = 0; v < 256; v++) begin
            tab[v] = CW'(v % SCREEN_WIDTH);
        end
        return tab;
    endfunction

    localparam t_row_tab ROW_TAB = f_row_tab();
    localparam t_col_tab COL_TAB = f_col_tab();

    logic [RW-1:0] y_wrap;
    logic [CW-1:0] x_wrap;
    logic [RW+1:0] row_sum;
    logic [RW+1:0] row_s1;
    logic [RW+1:0] row_s2;
    logic [CW:0]   col_sum [SPRITE_BITS_L];

    assign y_wrap     = ROW_TAB[i_y_pos];
    assign x_wrap     = COL_TAB[i_x_pos];
    assign o_read_row = y_wrap;
    assign o_read_col = x_wrap;

    // Row of a draw: wrapped start row plus index stays below three heights
    always_comb begin
        row_sum = {2'b00, y_wrap} + (RW+2)'(i_sprite_line);
        row_s1  = (row_sum >= HEIGHT_V) ? row_sum - HEIGHT_V : row_sum;
        row_s2  = (row_s1 >= HEIGHT_V) ? row_s1 - HEIGHT_V : row_s1;
    end

    assign o_draw_row = row_s2[RW-1:0];

    // Column mask; the width is at least eight, so one subtract wraps
    always_comb begin
        o_draw_mask = '0;
        for (int i = 0; i < SPRITE_BITS_L; i++) begin
            col_sum[i] = {1'b0, x_wrap} + (CW+1)'(i);
            if (col_sum[i] >= WIDTH_V) begin
                col_sum[i] = col_sum[i] - WIDTH_V;
            end
            if (i_sprite_byte[SPRITE_BITS_L-1-i]) begin
                o_draw_mask[col_sum[i][CW-1:0]] = 1'b1;
            end
        end
    end

endmodule

// File: rtl/sxf_frame_mem.sv
// Frame store: one row per entry, registered read, one write port.
// Per-row valid bits make a blanked row read as zero.
module sxf_frame_mem #(
    parameter int ROWS = 32,
    parameter int COLS = 64
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  sxf_pkg::t_mem_ctl       i_ctl,
    input  logic [$clog2(ROWS)-1:0] i_rd_addr,
    input  logic [$clog2(ROWS)-1:0] i_wr_addr,
    input  logic [COLS-1:0]         i_wr_data,
    output logic [COLS-1:0]         o_rd_data
);

    logic [COLS-1:0] r_mem [ROWS];
    logic [COLS-1:0] r_rd_data;
    logic [ROWS-1:0] r_row_ok;
    logic            r_rd_ok;

    // Storage array
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // Row valid bits; reset and clear blank the frame at once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_ok <= '0;
            r_rd_ok  <= 1'b0;
        end else begin
            if (i_ctl.clr_all) begin
                r_row_ok <= '0;
            end else if (i_ctl.wr_en) begin
                r_row_ok[i_wr_addr] <= 1'b1;
            end
            if (i_ctl.rd_en) begin
                r_rd_ok <= r_row_ok[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_ok ? r_rd_data : '0;

endmodule

// File: tb/sprite_xor_framebuffer_core_tb.sv
`timescale 1ns / 1ps

module sprite_xor_framebuffer_core_tb;

    localparam int SCREEN_WIDTH  = 64;
    localparam int SCREEN_HEIGHT = 32;
    localparam logic [1:0] KIND_SPARE = 2'd3;   // unused kind, must be a no-op
    localparam int TOTAL_WORDS   = 1300;
    localparam int LONG_HOLD     = 150;

    typedef struct {
        logic [1:0] kind;
        logic [7:0] x_pos;
        logic [7:0] y_pos;
        logic [3:0] sprite_line;
        logic [7:0] sprite_bits;
        logic       first_row;
    } t_draw_word;

    typedef struct {
        logic collision;
        logic pixel_on;
    } t_pixel_flags;

    logic       i_clk;
    logic       i_rst_n       = 1'b0;
    logic       i_in_valid    = 1'b0;
    logic       o_in_ready;
    logic [1:0] i_kind        = sxf_pkg::KIND_CLEAR;
    logic [7:0] i_x_pos       = '0;
    logic [7:0] i_y_pos       = '0;
    logic [3:0] i_sprite_line = '0;
    logic [7:0] i_sprite_byte = '0;
    logic       i_first_row   = 1'b0;
    logic       o_out_valid;
    logic       i_out_ready   = 1'b0;
    logic       o_collision;
    logic       o_pixel_on;

    // shadow copy of the screen and the collision flag
    logic [SCREEN_WIDTH-1:0] shadow_rows [SCREEN_HEIGHT];
    logic                    shadow_collision;

    t_draw_word   draw_items [$];
    t_pixel_flags due_flags [$];
    t_draw_word   cur_word;

    int words_taken  = 0;
    int flags_seen   = 0;
    int fail_count   = 0;
    int drain_a      = -1;
    int drain_b      = -1;
    int tx_cycles    = 0;
    int rx_cycles    = 0;
    int send_gap     = 0;
    int rx_stall     = 0;
    int long_hold    = 0;
    bit long_hold_done = 1'b0;

    sprite_xor_framebuffer_core #(
        .SCREEN_WIDTH (SCREEN_WIDTH),
        .SCREEN_HEIGHT(SCREEN_HEIGHT)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_kind       (i_kind),
        .i_x_pos      (i_x_pos),
        .i_y_pos      (i_y_pos),
        .i_sprite_line(i_sprite_line),
        .i_sprite_byte(i_sprite_byte),
        .i_first_row  (i_first_row),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_collision  (o_collision),
        .o_pixel_on   (o_pixel_on)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // apply one word to the shadow screen, return the flags it should give
    function automatic t_pixel_flags xor_draw_step(input t_draw_word w);
        t_pixel_flags res;
        int row;
        int col;
        res.pixel_on = 1'b0;
        unique case (w.kind)
            sxf_pkg::KIND_CLEAR: begin
                for (int r = 0; r < SCREEN_HEIGHT; r++) shadow_rows[r] = '0;
            end
            sxf_pkg::KIND_DRAW: begin
                if (w.first_row) shadow_collision = 1'b0;
                row = (int'(w.y_pos) + int'(w.sprite_line)) % SCREEN_HEIGHT;
                for (int i = 0; i < sxf_pkg::SPRITE_BITS; i++) begin
                    if (w.sprite_bits[sxf_pkg::SPRITE_BITS-1-i]) begin
                        col = (int'(w.x_pos) + i) % SCREEN_WIDTH;
                        if (shadow_rows[row][col]) shadow_collision = 1'b1;
                        shadow_rows[row][col] = ~shadow_rows[row][col];
                    end
                end
            end
            sxf_pkg::KIND_READ: begin
                row = int'(w.y_pos) % SCREEN_HEIGHT;
                col = int'(w.x_pos) % SCREEN_WIDTH;
                res.pixel_on = shadow_rows[row][col];
            end
            default: ;
        endcase
        res.collision = shadow_collision;
        return res;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 85) return $urandom_range(1, 3);
        if (p < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic add_word(input logic [1:0] kind, input logic [7:0] x, input logic [7:0] y,
                            input logic [3:0] ri, input logic [7:0] bits, input logic first);
        t_draw_word w;
        w.kind        = kind;
        w.x_pos       = x;
        w.y_pos       = y;
        w.sprite_line = ri;
        w.sprite_bits = bits;
        w.first_row   = first;
        draw_items.push_back(w);
    endtask

    // sender: offers queued words, random gaps, pauses at the drain points
    always @(posedge i_clk) begin
        logic offer;
        logic tx_quiet;
        logic holding;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            tx_cycles++;
            tx_quiet = (tx_cycles % 600) < 150;
            offer = i_in_valid;
            if (i_in_valid && o_in_ready) begin
                due_flags.push_back(xor_draw_step(cur_word));
                words_taken++;
                offer = 1'b0;
                send_gap = tx_quiet ? 0 : pick_gap();
            end
            holding = (words_taken == drain_a || words_taken == drain_b) &&
                      (words_taken != flags_seen);
            if (!offer) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (!holding && draw_items.size() > 0) begin
                    cur_word = draw_items.pop_front();
                    i_kind        <= cur_word.kind;
                    i_x_pos       <= cur_word.x_pos;
                    i_y_pos       <= cur_word.y_pos;
                    i_sprite_line <= cur_word.sprite_line;
                    i_sprite_byte <= cur_word.sprite_bits;
                    i_first_row   <= cur_word.first_row;
                    offer = 1'b1;
                end
            end
            i_in_valid <= offer;
        end
    end

    // receiver: checks each result word, random stalls, one long hold-off
    always @(posedge i_clk) begin
        t_pixel_flags want;
        logic take;
        logic rx_quiet;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            rx_cycles++;
            rx_quiet = (rx_cycles % 700) >= 520;
            if (o_out_valid && i_out_ready) begin
                if (due_flags.size() == 0) begin
                    $error("result word with nothing expected");
                    fail_count++;
                end else begin
                    want = due_flags.pop_front();
                    if (o_collision !== want.collision) begin
                        $error("collision: expected %0b, got %0b", want.collision, o_collision);
                        fail_count++;
                    end
                    if (o_pixel_on !== want.pixel_on) begin
                        $error("pixel_on: expected %0b, got %0b", want.pixel_on, o_pixel_on);
                        fail_count++;
                    end
                end
                flags_seen++;
            end
            if (long_hold > 0) begin
                long_hold--;
                take = 1'b0;
            end else if (!long_hold_done && flags_seen >= 300) begin
                long_hold_done = 1'b1;
                long_hold = LONG_HOLD;
                take = 1'b0;
            end else if (rx_stall > 0) begin
                rx_stall--;
                take = 1'b0;
            end else if (rx_quiet) begin
                take = 1'b1;
            end else begin
                rx_stall = pick_gap();
                take = (rx_stall == 0);
            end
            i_out_ready <= take;
        end
    end

    initial begin
        #3_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        int pick;
        int rows;
        int total_words;
        logic [7:0] sx;
        logic [7:0] sy;

        for (int r = 0; r < SCREEN_HEIGHT; r++) shadow_rows[r] = '0;
        shadow_collision = 1'b0;

        // directed: fresh screen, collisions, wrapping, clear, spare kind
        add_word(sxf_pkg::KIND_READ,  8'd0,   8'd0,   4'd0,  8'h00, 1'b0);
        add_word(sxf_pkg::KIND_DRAW,  8'd0,   8'd0,   4'd0,  8'hFF, 1'b1);
        add_word(sxf_pkg::KIND_READ,  8'd7,   8'd0,   4'd0,  8'h00, 1'b0);
        add_word(sxf_pkg::KIND_READ,  8'd8,   8'd0,   4'd0,  8'h00, 1'b0);
        add_word(sxf_pkg::KIND_DRAW,  8'd0,   8'd0,   4'd0,  8'h81, 1'b0);
        add_word(sxf_pkg::KIND_DRAW,  8'd0,   8'd0,   4'd0,  8'h00, 1'b1);
        add_word(sxf_pkg::KIND_DRAW,  8'd60,  8'd31,  4'd1,  8'hFF, 1'b1);
        add_word(sxf_pkg::KIND_READ,  8'd63,  8'd0,   4'd0,  8'h00, 1'b0);
        add_word(sxf_pkg::KIND_READ,  8'd255, 8'd255, 4'd0,  8'h00, 1'b0);
        add_word(sxf_pkg::KIND_DRAW,  8'd255, 8'd255, 4'd15, 8'hAA, 1'b0);
        add_word(sxf_pkg::KIND_READ,  8'd255, 8'd14,  4'd15, 8'hFF, 1'b1);
        add_word(sxf_pkg::KIND_CLEAR, 8'd255, 8'd255, 4'd15, 8'hFF, 1'b1);
        add_word(sxf_pkg::KIND_READ,  8'd0,   8'd14,  4'd0,  8'h00, 1'b0);
        add_word(KIND_SPARE,          8'd255, 8'd255, 4'd15, 8'hFF, 1'b1);
        add_word(sxf_pkg::KIND_READ,  8'd2,   8'd0,   4'd15, 8'hFF, 1'b1);
        add_word(sxf_pkg::KIND_DRAW,  8'd56,  8'd16,  4'd15, 8'h01, 1'b1);
        add_word(sxf_pkg::KIND_READ,  8'd63,  8'd31,  4'd0,  8'h00, 1'b0);
        add_word(sxf_pkg::KIND_DRAW,  8'd128, 8'd64,  4'd0,  8'h80, 1'b0);
        add_word(sxf_pkg::KIND_READ,  8'd0,   8'd0,   4'd0,  8'h00, 1'b0);
        add_word(sxf_pkg::KIND_DRAW,  8'd7,   8'd0,   4'd0,  8'hFF, 1'b0);
        add_word(KIND_SPARE,          8'd0,   8'd0,   4'd0,  8'h00, 1'b0);
        add_word(sxf_pkg::KIND_DRAW,  8'd200, 8'd100, 4'd7,  8'h3C, 1'b0);
        add_word(sxf_pkg::KIND_READ,  8'd202, 8'd107, 4'd0,  8'h00, 1'b0);

        // sender waits for the directed part to drain, and again mid-run
        drain_a = draw_items.size();
        drain_b = 700;

        // random: mostly whole sprites with reads over them, the rest noise
        while (draw_items.size() < TOTAL_WORDS) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                sx = (pick < 40) ? 8'($urandom_range(0, 63)) : 8'($urandom_range(0, 255));
                sy = (pick < 40) ? 8'($urandom_range(0, 31)) : 8'($urandom_range(0, 255));
                rows = $urandom_range(1, 15);
                for (int r = 0; r < rows; r++)
                    add_word(sxf_pkg::KIND_DRAW, sx, sy, 4'(r), 8'($urandom), r == 0);
                repeat ($urandom_range(0, 3))
                    add_word(sxf_pkg::KIND_READ, sx + 8'($urandom_range(0, 7)),
                             sy + 8'($urandom_range(0, rows)), 4'($urandom),
                             8'($urandom), 1'($urandom));
            end else if (pick < 75) begin
                add_word(sxf_pkg::KIND_READ, 8'($urandom), 8'($urandom), 4'($urandom),
                         8'($urandom), 1'($urandom));
            end else if (pick < 94) begin
                add_word(sxf_pkg::KIND_DRAW, 8'($urandom), 8'($urandom), 4'($urandom),
                         8'($urandom), 1'($urandom));
            end else if (pick < 97) begin
                add_word(sxf_pkg::KIND_CLEAR, 8'($urandom), 8'($urandom), 4'($urandom),
                         8'($urandom), 1'($urandom));
            end else begin
                add_word(KIND_SPARE, 8'($urandom), 8'($urandom), 4'($urandom),
                         8'($urandom), 1'($urandom));
            end
        end
        total_words = draw_items.size();

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // every queued word must come back checked
        wait (flags_seen == total_words);
        repeat (20) @(posedge i_clk);

        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
